// ===== rtl/core/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg: motor starter supervisor shared definitions
// Phase codes, configuration register indexes, reset values and the item
// structures passed between the supervisor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

   localparam int TIMER_W    = 17;
   localparam int CFG_W      = 16;
   localparam int DELTA_W    = 8;
   localparam int CSR_IDX_W  = 2;

   localparam logic [TIMER_W-1:0] TIMER_MAX = 17'h1FFFF;

   localparam logic [CFG_W-1:0] RESPONSE_TIMEOUT_RESET = 16'd5000;
   localparam logic [CFG_W-1:0] ALERT_HOLD_RESET       = 16'd2000;

   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_HOLD       = 2'd1;

   typedef enum logic [3:0] {
      PH_STOPPED  = 4'b0001,
      PH_STARTING = 4'b0010,
      PH_RUNNING  = 4'b0100,
      PH_STOPPING = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] response_timeout_ms;
      logic [CFG_W-1:0] alert_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic               fb_running;
      logic               fb_stopped;
      logic               start_request;
      logic               stop_request;
      logic               start_permit;
      logic               stop_permit;
      logic [DELTA_W-1:0] delta_ms;
   } req_item_type;

   typedef struct packed {
      logic start_cmd;
      logic stop_cmd;
      logic is_starting;
      logic is_stopping;
      logic is_running;
      logic is_stopped;
      logic unexpected_start;
      logic unexpected_stop;
      logic failed_to_start;
      logic failed_to_stop;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/mss_csr.sv =====
// ----------------------------------------------------------------------------
// mss_csr: configuration registers
// Holds the response timeout and alert hold times; writes to unused indexes
// are accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_csr
   import mss_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RESPONSE_TIMEOUT: cfg_in.response_timeout_ms = csr_data;
            CSR_ALERT_HOLD:       cfg_in.alert_hold_ms       = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.response_timeout_ms <= RESPONSE_TIMEOUT_RESET;
         cfg_ff.alert_hold_ms       <= ALERT_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mss_core.sv =====
// ----------------------------------------------------------------------------
// mss_core: supervisor state and step logic
// Holds phase, status, alerts, command latches and timers; computes the
// result of one item and commits the new state when advance is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_core
   import mss_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire req_item_type item,
   input  wire cfg_type      cfg,
   output rsp_item_type      result
);

   phase_type          phase_ff, phase_in;
   logic [3:0]         status_ff, status_in;
   logic               ux_start_ff, ux_start_in;
   logic               ux_stop_ff, ux_stop_in;
   logic               ft_start_ff, ft_start_in;
   logic               ft_stop_ff, ft_stop_in;
   logic               cmd_start_ff, cmd_start_in;
   logic               cmd_stop_ff, cmd_stop_in;
   logic [TIMER_W-1:0] resp_timer_ff, resp_timer_in;
   logic [TIMER_W-1:0] alert_timer_ff, alert_timer_in;
   logic               alert_active_ff, alert_active_in;

   logic [TIMER_W:0]   resp_sum;
   logic [TIMER_W:0]   alert_sum;
   logic [TIMER_W-1:0] resp_sat;
   logic [TIMER_W-1:0] alert_sat;
   logic               timed_out;

   // saturating timer advance
   always_comb begin
      resp_sum  = {1'b0, resp_timer_ff} + (TIMER_W+1)'(item.delta_ms);
      alert_sum = {1'b0, alert_timer_ff} + (TIMER_W+1)'(item.delta_ms);
      resp_sat  = resp_sum[TIMER_W] ? TIMER_MAX : resp_sum[TIMER_W-1:0];
      alert_sat = alert_sum[TIMER_W] ? TIMER_MAX : alert_sum[TIMER_W-1:0];
      timed_out = resp_sat > {1'b0, cfg.response_timeout_ms};
   end

   always_comb begin
      phase_in        = phase_ff;
      ux_start_in     = ux_start_ff;
      ux_stop_in      = ux_stop_ff;
      ft_start_in     = ft_start_ff;
      ft_stop_in      = ft_stop_ff;
      cmd_start_in    = cmd_start_ff;
      cmd_stop_in     = cmd_stop_ff;
      resp_timer_in   = resp_sat;
      alert_timer_in  = alert_active_ff ? alert_sat : alert_timer_ff;
      alert_active_in = alert_active_ff;

      // feedback moves the phase; a transition in progress holds
      if (item.fb_running && !item.fb_stopped) begin
         phase_in = PH_RUNNING;
         if (status_ff == PH_STOPPED) ux_start_in = 1'b1;
      end
      if (item.fb_stopped && !item.fb_running) begin
         phase_in = PH_STOPPED;
         if (status_ff == PH_RUNNING) ux_stop_in = 1'b1;
      end
      if (status_ff == PH_STARTING) phase_in = PH_STARTING;
      if (status_ff == PH_STOPPING) phase_in = PH_STOPPING;

      unique case (phase_in)
         PH_STOPPED: begin
            if (item.start_request && item.start_permit) begin
               phase_in      = PH_STARTING;
               resp_timer_in = '0;
               cmd_start_in  = 1'b1;
            end
         end
         PH_STOPPING: begin
            if (item.fb_stopped) begin
               phase_in      = PH_STOPPED;
               resp_timer_in = '0;
               cmd_stop_in   = 1'b0;
            end else if (timed_out) begin
               phase_in      = PH_RUNNING;
               resp_timer_in = '0;
               ft_stop_in    = 1'b1;
               cmd_stop_in   = 1'b0;
            end else if (item.start_request) begin
               phase_in      = PH_STARTING;
               resp_timer_in = '0;
               cmd_stop_in   = 1'b0;
               cmd_start_in  = 1'b1;
            end
         end
         PH_RUNNING: begin
            if (item.stop_request && item.stop_permit) begin
               phase_in      = PH_STOPPING;
               resp_timer_in = '0;
               cmd_stop_in   = 1'b1;
            end
         end
         PH_STARTING: begin
            if (item.fb_running) begin
               phase_in      = PH_RUNNING;
               resp_timer_in = '0;
               cmd_start_in  = 1'b0;
            end else if (timed_out) begin
               phase_in      = PH_STOPPED;
               resp_timer_in = '0;
               ft_start_in   = 1'b1;
               cmd_start_in  = 1'b0;
            end else if (item.stop_request) begin
               phase_in      = PH_STOPPING;
               resp_timer_in = '0;
               cmd_stop_in   = 1'b1;
               cmd_start_in  = 1'b0;
            end
         end
         default: phase_in = phase_ff;
      endcase

      status_in = phase_in;

      // alert episode: start the hold timer once, clear all when it expires
      if (ux_start_in || ux_stop_in || ft_start_in || ft_stop_in) begin
         if (!alert_active_ff) begin
            alert_active_in = 1'b1;
            alert_timer_in  = '0;
         end
         if (alert_timer_in > {1'b0, cfg.alert_hold_ms}) begin
            ux_start_in     = 1'b0;
            ux_stop_in      = 1'b0;
            ft_start_in     = 1'b0;
            ft_stop_in      = 1'b0;
            alert_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_STOPPED;
         status_ff       <= '0;
         ux_start_ff     <= 1'b0;
         ux_stop_ff      <= 1'b0;
         ft_start_ff     <= 1'b0;
         ft_stop_ff      <= 1'b0;
         cmd_start_ff    <= 1'b0;
         cmd_stop_ff     <= 1'b0;
         resp_timer_ff   <= '0;
         alert_timer_ff  <= '0;
         alert_active_ff <= 1'b0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         status_ff       <= status_in;
         ux_start_ff     <= ux_start_in;
         ux_stop_ff      <= ux_stop_in;
         ft_start_ff     <= ft_start_in;
         ft_stop_ff      <= ft_stop_in;
         cmd_start_ff    <= cmd_start_in;
         cmd_stop_ff     <= cmd_stop_in;
         resp_timer_ff   <= resp_timer_in;
         alert_timer_ff  <= alert_timer_in;
         alert_active_ff <= alert_active_in;
      end
   end

   always_comb begin
      result.start_cmd        = cmd_start_in;
      result.stop_cmd         = cmd_stop_in;
      result.is_starting      = (status_in == PH_STARTING);
      result.is_stopping      = (status_in == PH_STOPPING);
      result.is_running       = (status_in == PH_RUNNING);
      result.is_stopped       = (status_in == PH_STOPPED);
      result.unexpected_start = ux_start_in;
      result.unexpected_stop  = ux_stop_in;
      result.failed_to_start  = ft_start_in;
      result.failed_to_stop   = ft_stop_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/motor_starter_supervisor.sv =====
// ----------------------------------------------------------------------------
// motor_starter_supervisor: starter supervision with feedback checking
// Each request transfer carries feedback, requests, interlocks and elapsed
// milliseconds; each produces one response transfer with commands, phase
// status and latched alerts.
//
// Channels: req_* in, rsp_* out, both valid/ready. csr_* writes register 0
// (response timeout, ms) or 1 (alert hold, ms); csr_ready is always high and
// other indexes are dropped. Write configuration only while idle.
// Path: a request transfer lands in the input register, is evaluated in
// one pass against the supervisor state and lands in the response
// register once that register has room.
// Throughput: one transfer per cycle while rsp_ready is high; the state
// update is a single pass of saturating adds, two compares and the phase
// selection.
// Reset: phase stopped, all status flags, alerts, commands and timers clear,
// timeout 5000 ms and hold 2000 ms; both pipeline stages empty.
// Stall: when rsp_ready is low the response holds, the input register holds
// its item and req_ready drops once it is full; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_starter_supervisor
   import mss_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_fb_running,
   input  wire logic                 req_fb_stopped,
   input  wire logic                 req_start_request,
   input  wire logic                 req_stop_request,
   input  wire logic                 req_start_permit,
   input  wire logic                 req_stop_permit,
   input  wire logic [DELTA_W-1:0]   req_delta_ms,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_start_cmd,
   output logic                      rsp_stop_cmd,
   output logic                      rsp_is_starting,
   output logic                      rsp_is_stopping,
   output logic                      rsp_is_running,
   output logic                      rsp_is_stopped,
   output logic                      rsp_unexpected_start,
   output logic                      rsp_unexpected_stop,
   output logic                      rsp_failed_to_start,
   output logic                      rsp_failed_to_stop,

   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type in_item_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type step_result;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;

   mss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   always_comb begin
      req_item.fb_running    = req_fb_running;
      req_item.fb_stopped    = req_fb_stopped;
      req_item.start_request = req_start_request;
      req_item.stop_request  = req_stop_request;
      req_item.start_permit  = req_start_permit;
      req_item.stop_permit   = req_stop_permit;
      req_item.delta_ms      = req_delta_ms;
   end

   // advance the held item into the response register when it has room
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance)   in_valid_in = 1'b0;
      if (req_valid && req_ready) in_valid_in = 1'b1;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (advance) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_item;
      if (advance) rsp_item_ff <= step_result;
   end

   mss_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_start_cmd        = rsp_item_ff.start_cmd;
   assign rsp_stop_cmd         = rsp_item_ff.stop_cmd;
   assign rsp_is_starting      = rsp_item_ff.is_starting;
   assign rsp_is_stopping      = rsp_item_ff.is_stopping;
   assign rsp_is_running       = rsp_item_ff.is_running;
   assign rsp_is_stopped       = rsp_item_ff.is_stopped;
   assign rsp_unexpected_start = rsp_item_ff.unexpected_start;
   assign rsp_unexpected_stop  = rsp_item_ff.unexpected_stop;
   assign rsp_failed_to_start  = rsp_item_ff.failed_to_start;
   assign rsp_failed_to_stop   = rsp_item_ff.failed_to_stop;

endmodule

`default_nettype wire

// ===== test/motor_starter_supervisor_test.sv =====
// ----------------------------------------------------------------------------
// motor_starter_supervisor_test: self-checking bench for the starter supervisor
// Drives request transfers through the valid/ready channel and predicts every
// response with a behavioural copy of the supervisor state. The run covers
// directed phase cases, register writes, back-pressure, long timeouts and a
// plant-driven random mix under four pacing regimes.
// ----------------------------------------------------------------------------

module motor_starter_supervisor_test;
   import mss_pkg::*;

   // indexes with no register behind them; writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   logic clock;
   logic reset;

   logic               req_valid;
   logic               req_ready;
   logic               req_fb_running;
   logic               req_fb_stopped;
   logic               req_start_request;
   logic               req_stop_request;
   logic               req_start_permit;
   logic               req_stop_permit;
   logic [DELTA_W-1:0] req_delta_ms;

   logic rsp_valid;
   logic rsp_ready;
   logic rsp_start_cmd;
   logic rsp_stop_cmd;
   logic rsp_is_starting;
   logic rsp_is_stopping;
   logic rsp_is_running;
   logic rsp_is_stopped;
   logic rsp_unexpected_start;
   logic rsp_unexpected_stop;
   logic rsp_failed_to_start;
   logic rsp_failed_to_stop;

   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   motor_starter_supervisor u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_fb_running       (req_fb_running),
      .req_fb_stopped       (req_fb_stopped),
      .req_start_request    (req_start_request),
      .req_stop_request     (req_stop_request),
      .req_start_permit     (req_start_permit),
      .req_stop_permit      (req_stop_permit),
      .req_delta_ms         (req_delta_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_start_cmd        (rsp_start_cmd),
      .rsp_stop_cmd         (rsp_stop_cmd),
      .rsp_is_starting      (rsp_is_starting),
      .rsp_is_stopping      (rsp_is_stopping),
      .rsp_is_running       (rsp_is_running),
      .rsp_is_stopped       (rsp_is_stopped),
      .rsp_unexpected_start (rsp_unexpected_start),
      .rsp_unexpected_stop  (rsp_unexpected_stop),
      .rsp_failed_to_start  (rsp_failed_to_start),
      .rsp_failed_to_stop   (rsp_failed_to_stop),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // ---------------------------------------------------------------------
   // Shared bench state
   // ---------------------------------------------------------------------
   rsp_item_type expected_outputs [$];

   int error_count      = 0;
   int requests_sent    = 0;
   int responses_seen   = 0;
   int register_writes  = 0;

   // pacing knobs, percent of cycles spent idle or stalled
   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   int hold_off_left    = 0;

   // plant model knobs for the random traffic
   int plant_response_pct = 30;
   int noise_pct          = 10;
   bit plant_running      = 1'b0;

   string field_names [0:9] = '{"start_cmd", "stop_cmd", "is_starting", "is_stopping",
                                "is_running", "is_stopped", "unexpected_start",
                                "unexpected_stop", "failed_to_start", "failed_to_stop"};

   // ---------------------------------------------------------------------
   // Supervisor prediction: own copy of configuration and state
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0]   timeout_limit_ms;
   logic [CFG_W-1:0]   hold_limit_ms;
   phase_type          model_phase;
   logic               model_starting, model_stopping, model_running, model_stopped;
   logic               alarm_ux_start, alarm_ux_stop, alarm_ft_start, alarm_ft_stop;
   logic               cmd_start_q, cmd_stop_q;
   logic [TIMER_W-1:0] response_ms;
   logic [TIMER_W-1:0] alert_ms;
   logic               alert_counting;

   function automatic void clear_supervisor_model();
      timeout_limit_ms = RESPONSE_TIMEOUT_RESET;
      hold_limit_ms    = ALERT_HOLD_RESET;
      model_phase      = PH_STOPPED;
      // status flags start clear, so is_stopped reads low until the first step
      {model_starting, model_stopping, model_running, model_stopped} = 4'b0000;
      {alarm_ux_start, alarm_ux_stop, alarm_ft_start, alarm_ft_stop} = 4'b0000;
      {cmd_start_q, cmd_stop_q} = 2'b00;
      response_ms    = '0;
      alert_ms       = '0;
      alert_counting = 1'b0;
   endfunction

   function automatic logic [TIMER_W-1:0] sat_advance(input logic [TIMER_W-1:0] t,
                                                      input logic [DELTA_W-1:0] d);
      logic [TIMER_W:0] sum;
      sum = {1'b0, t} + {{(TIMER_W+1-DELTA_W){1'b0}}, d};
      return (sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : sum[TIMER_W-1:0];
   endfunction

   function automatic void show_phase(input phase_type p);
      model_starting = (p == PH_STARTING);
      model_stopping = (p == PH_STOPPING);
      model_running  = (p == PH_RUNNING);
      model_stopped  = (p == PH_STOPPED);
   endfunction

   // a transition made by the phase machine restarts the response timer
   function automatic void enter_phase(input phase_type p);
      model_phase = p;
      show_phase(p);
      response_ms = '0;
   endfunction

   function automatic rsp_item_type predict_starter_outputs(input req_item_type it);
      rsp_item_type o;
      logic         timed_out;
      response_ms = sat_advance(response_ms, it.delta_ms);
      if (alert_counting)
         alert_ms = sat_advance(alert_ms, it.delta_ms);

      // unambiguous feedback moves the phase; a sequence in progress holds it
      if (it.fb_running && !it.fb_stopped) begin
         model_phase = PH_RUNNING;
         if (model_stopped)
            alarm_ux_start = 1'b1;
      end
      if (it.fb_stopped && !it.fb_running) begin
         model_phase = PH_STOPPED;
         if (model_running)
            alarm_ux_stop = 1'b1;
      end
      if (model_starting)
         model_phase = PH_STARTING;
      if (model_stopping)
         model_phase = PH_STOPPING;
      show_phase(model_phase);
      timed_out = (response_ms > {1'b0, timeout_limit_ms});

      case (model_phase)
         PH_STOPPED: begin
            if (it.start_request && it.start_permit) begin
               enter_phase(PH_STARTING);
               cmd_start_q = 1'b1;
            end
         end
         PH_STOPPING: begin
            if (it.fb_stopped) begin
               enter_phase(PH_STOPPED);
               cmd_stop_q = 1'b0;
            end else if (timed_out) begin
               enter_phase(PH_RUNNING);
               alarm_ft_stop = 1'b1;
               cmd_stop_q    = 1'b0;
            end else if (it.start_request) begin
               enter_phase(PH_STARTING);
               cmd_stop_q  = 1'b0;
               cmd_start_q = 1'b1;
            end
         end
         PH_RUNNING: begin
            if (it.stop_request && it.stop_permit) begin
               enter_phase(PH_STOPPING);
               cmd_stop_q = 1'b1;
            end
         end
         default: begin
            if (it.fb_running) begin
               enter_phase(PH_RUNNING);
               cmd_start_q = 1'b0;
            end else if (timed_out) begin
               enter_phase(PH_STOPPED);
               alarm_ft_start = 1'b1;
               cmd_start_q    = 1'b0;
            end else if (it.stop_request) begin
               enter_phase(PH_STOPPING);
               cmd_stop_q  = 1'b1;
               cmd_start_q = 1'b0;
            end
         end
      endcase

      // one alert timer per episode; clear every alert once the hold expires
      if (alarm_ux_start || alarm_ux_stop || alarm_ft_start || alarm_ft_stop) begin
         if (!alert_counting) begin
            alert_counting = 1'b1;
            alert_ms       = '0;
         end
         if (alert_ms > {1'b0, hold_limit_ms}) begin
            {alarm_ux_start, alarm_ux_stop, alarm_ft_start, alarm_ft_stop} = 4'b0000;
            alert_counting = 1'b0;
         end
      end

      o = {cmd_start_q, cmd_stop_q, model_starting, model_stopping, model_running,
           model_stopped, alarm_ux_start, alarm_ux_stop, alarm_ft_start, alarm_ft_stop};
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, time limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // generous ceiling on the simulation time
   initial begin
      #2000000;
      $display("motor_starter_supervisor_test: errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: sample at the rising edge, pace ready at the falling edge
   // ---------------------------------------------------------------------
   initial begin
      rsp_item_type got;
      rsp_item_type want;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_start_cmd, rsp_stop_cmd, rsp_is_starting, rsp_is_stopping,
                   rsp_is_running, rsp_is_stopped, rsp_unexpected_start,
                   rsp_unexpected_stop, rsp_failed_to_start, rsp_failed_to_stop};
            responses_seen++;
            if (expected_outputs.size() == 0) begin
               error_count++;
               $display("%0t: response transfer with nothing outstanding, got %b",
                        $time, got);
            end else begin
               want = expected_outputs.pop_front();
               for (int i = 0; i < 10; i++) begin
                  if (got[9-i] !== want[9-i]) begin
                     error_count++;
                     // keep the log readable on a badly broken build
                     if (error_count <= 200)
                        $display("%0t: %s expected %b actual %b", $time,
                                 field_names[i], want[9-i], got[9-i]);
                  end
               end
            end
         end
         @(negedge clock);
         // a long hold-off is counted here, in cycles, independent of the sender
         if (hold_off_left > 0) begin
            rsp_ready = 1'b0;
            hold_off_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side helpers; all called and returning at a falling edge
   // ---------------------------------------------------------------------
   task automatic send_item(input req_item_type item);
      // idle gaps before offering, then hold valid and payload until transfer
      while ($urandom_range(99) < send_idle_pct)
         @(negedge clock);
      req_valid         = 1'b1;
      req_fb_running    = item.fb_running;
      req_fb_stopped    = item.fb_stopped;
      req_start_request = item.start_request;
      req_stop_request  = item.stop_request;
      req_start_permit  = item.start_permit;
      req_stop_permit   = item.stop_permit;
      req_delta_ms      = item.delta_ms;
      do
         @(posedge clock);
      while (!req_ready);
      expected_outputs.push_back(predict_starter_outputs(item));
      requests_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do
         @(posedge clock);
      while (!csr_ready);
      // unused indexes are dropped by the block
      if (idx == CSR_RESPONSE_TIMEOUT)
         timeout_limit_ms = value;
      else if (idx == CSR_ALERT_HOLD)
         hold_limit_ms = value;
      register_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drain all outstanding responses, then allow for the two-stage pipeline
   task automatic wait_idle();
      while (expected_outputs.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic req_item_type pack_request(input bit fr, input bit fs, input bit sr,
                                                 input bit pr, input bit sp, input bit pp,
                                                 input logic [DELTA_W-1:0] d);
      req_item_type it;
      it.fb_running    = fr;
      it.fb_stopped    = fs;
      it.start_request = sr;
      it.stop_request  = pr;
      it.start_permit  = sp;
      it.stop_permit   = pp;
      it.delta_ms      = d;
      return it;
   endfunction

   // plant that answers the latched commands after a random lag, with
   // occasional spontaneous flips, contradictory feedback and pure noise
   function automatic req_item_type next_plant_item();
      req_item_type it;
      if ($urandom_range(99) < noise_pct) begin
         it = req_item_type'(14'($urandom));
      end else begin
         if (cmd_start_q && !plant_running && $urandom_range(99) < plant_response_pct)
            plant_running = 1'b1;
         else if (cmd_stop_q && plant_running && $urandom_range(99) < plant_response_pct)
            plant_running = 1'b0;
         else if ($urandom_range(99) < 2)
            plant_running = !plant_running;
         it.fb_running = plant_running;
         it.fb_stopped = !plant_running;
         if ($urandom_range(99) < 6)
            it.fb_stopped = it.fb_running;
         it.start_request = ($urandom_range(99) < 20);
         it.stop_request  = ($urandom_range(99) < 20);
         it.start_permit  = ($urandom_range(99) < 85);
         it.stop_permit   = ($urandom_range(99) < 85);
         case ($urandom_range(9))
            0:       it.delta_ms = '0;
            1:       it.delta_ms = '1;
            default: it.delta_ms = 8'($urandom_range(60));
         endcase
      end
      return it;
   endfunction

   function automatic logic [CFG_W-1:0] pick_ms();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return 16'($urandom_range(600, 1));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // walk every phase edge, the no-permit paths, both priority orders and an
   // alert episode with short timeout and hold
   task automatic test_directed_phases();
      write_csr(CSR_RESPONSE_TIMEOUT, 16'd300);
      write_csr(CSR_ALERT_HOLD, 16'd100);
      write_csr(CSR_SPARE_LOW, 16'hFFFF);
      write_csr(CSR_SPARE_HIGH, 16'h0000);
      // first step after reset: status is clear, so no unexpected start
      send_item(pack_request(1, 0, 0, 0, 0, 0, 8'd0));
      send_item(pack_request(1, 0, 0, 1, 0, 0, 8'd10));   // stop without permit
      send_item(pack_request(1, 0, 0, 1, 0, 1, 8'd255));  // stop with permit
      send_item(pack_request(0, 0, 1, 0, 0, 0, 8'd5));    // start while stopping, no permit
      send_item(pack_request(0, 0, 0, 1, 0, 0, 8'd5));    // stop while starting, no permit
      send_item(pack_request(0, 1, 0, 0, 0, 0, 8'd5));    // stopped feedback
      send_item(pack_request(1, 1, 0, 0, 0, 0, 8'd5));    // contradictory, both high
      send_item(pack_request(0, 0, 0, 0, 0, 0, 8'd5));    // contradictory, both low
      send_item(pack_request(1, 0, 0, 0, 0, 0, 8'd5));    // unexpected start
      send_item(pack_request(1, 0, 0, 0, 0, 0, 8'd60));
      send_item(pack_request(1, 0, 0, 0, 0, 0, 8'd60));   // hold expires, alerts clear
      send_item(pack_request(0, 1, 0, 0, 0, 0, 8'd0));    // unexpected stop
      send_item(pack_request(0, 1, 1, 0, 1, 0, 8'd0));    // start with permit
      send_item(pack_request(0, 0, 0, 0, 0, 0, 8'd200));
      send_item(pack_request(1, 0, 0, 1, 0, 0, 8'd200));  // feedback beats timeout and stop
      send_item(pack_request(1, 0, 0, 1, 0, 1, 8'd0));
      send_item(pack_request(0, 0, 0, 0, 0, 0, 8'd200));
      send_item(pack_request(0, 1, 1, 0, 0, 0, 8'd200));  // feedback beats timeout and start
      send_item(pack_request(0, 1, 1, 0, 1, 0, 8'd0));
      send_item(pack_request(0, 0, 0, 0, 0, 0, 8'd200));
      send_item(pack_request(0, 0, 0, 1, 0, 0, 8'd200));  // timeout beats stop: failed start
      send_item(pack_request(0, 0, 1, 0, 1, 0, 8'd0));
      send_item(pack_request(0, 0, 0, 1, 0, 0, 8'd0));
      send_item(pack_request(0, 0, 0, 0, 0, 0, 8'd200));
      send_item(pack_request(0, 0, 1, 0, 0, 0, 8'd200));  // timeout beats start: failed stop
      send_item(pack_request(0, 0, 0, 1, 0, 1, 8'd0));
      send_item(pack_request(0, 0, 1, 0, 1, 0, 8'd0));
      wait_idle();
   endtask

   // hold the receiver off for a long stretch while items keep coming, so the
   // pipeline fills and stalls its input; then pause until everything drains
   task automatic test_back_pressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_left  = 200;
      repeat (40) send_item(next_plant_item());
      wait_idle();
   endtask

   // largest timeout and hold: a start that never gets feedback must fail only
   // after the full window, and the alert must outlast the full hold
   task automatic test_long_timeouts();
      write_csr(CSR_RESPONSE_TIMEOUT, 16'hFFFF);
      write_csr(CSR_ALERT_HOLD, 16'hFFFF);
      repeat (3) send_item(pack_request(0, 1, 0, 1, 0, 1, 8'd1));
      send_item(pack_request(0, 1, 1, 0, 1, 0, 8'd0));
      repeat (520) send_item(pack_request(0, 0, 0, 0, 0, 0, 8'd255));
      wait_idle();
   endtask

   // plant-driven traffic in bursts, with fresh register values between bursts
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_items);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int b = 0; b < 3; b++) begin
         wait_idle();
         write_csr(CSR_RESPONSE_TIMEOUT, pick_ms());
         write_csr(CSR_ALERT_HOLD, pick_ms());
         case ($urandom_range(2))
            0:       plant_response_pct = 5;
            1:       plant_response_pct = 30;
            default: plant_response_pct = 70;
         endcase
         noise_pct = 10;
         repeat (n_items / 3) send_item(next_plant_item());
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_fb_running    = 1'b0;
      req_fb_stopped    = 1'b0;
      req_start_request = 1'b0;
      req_stop_request  = 1'b0;
      req_start_permit  = 1'b0;
      req_stop_permit   = 1'b0;
      req_delta_ms      = '0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      clear_supervisor_model();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed_phases();
      test_back_pressure();
      test_long_timeouts();
      test_random_traffic(0, 0, 84);
      test_random_traffic(53, 0, 84);
      test_random_traffic(0, 53, 84);
      test_random_traffic(16, 16, 84);

      // settle: nothing outstanding, allow the pipeline latency to pass
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_idle();
      repeat (10) @(negedge clock);

      $display("covered %0d request transfers, %0d responses, %0d register writes",
               requests_sent, responses_seen, register_writes);
      $display("phase edges, priorities, alert hold, long stalls and four pacing mixes");
      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("motor_starter_supervisor_test: clean");
      end else begin
         $display("motor_starter_supervisor_test: errors");
      end
      $finish;
   end

endmodule
